[sv/motor_command_frame_encoder_top_defines.svh]
// ---------------------------------------------------------------------------
// motor command frame encoder assertion macros
// shared property wrappers for the encoder checks
// ---------------------------------------------------------------------------
`ifndef MOTOR_COMMAND_FRAME_ENCODER_TOP_DEFINES_SVH
`define MOTOR_COMMAND_FRAME_ENCODER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MCFE_ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("mcfe check failed (same cycle)");

// next-cycle implication, disabled in reset
`define MCFE_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("mcfe check failed (next cycle)");

`endif

[sv/mcfe_pkg.sv]
// ---------------------------------------------------------------------------
// mcfe_pkg
// types and constants shared by the motor command frame encoder
// ---------------------------------------------------------------------------
package mcfe_pkg;

    typedef enum logic [2:0] {
        FUNC_EC_MIT    = 3'd0,
        FUNC_DM_MIT    = 3'd1,
        FUNC_ENABLE    = 3'd2,
        FUNC_ZERO      = 3'd3,
        FUNC_CLEAR     = 3'd4,
        FUNC_QUERY_POS = 3'd5,
        FUNC_QUERY_VEL = 3'd6,
        FUNC_QUERY_CUR = 3'd7
    } func_t;

    localparam int SP_W        = 24;
    localparam int ID_W        = 11;
    localparam int LEN_W       = 4;
    localparam int NUM_SP      = 5;
    localparam int LIM_W       = 27;
    localparam int D_W         = 25;
    localparam int Q_W         = 22;
    localparam int CODE_W      = 16;
    localparam int SPAN_W      = 10;
    localparam int RECIP_W     = 32;
    localparam int RECIP_SHIFT = 32;

    localparam int FIELD_KP = 0;
    localparam int FIELD_KD = 1;
    localparam int FIELD_PS = 2;
    localparam int FIELD_VL = 3;
    localparam int FIELD_TQ = 4;

    // limits in half units: stiffness, damping, position, speed, torque
    localparam int EC_LO2  [NUM_SP] = '{0, 0, -25, -36, -60};
    localparam int EC_HI2  [NUM_SP] = '{1000, 10, 25, 36, 60};
    localparam int EC_BITS [NUM_SP] = '{12, 9, 16, 12, 12};
    localparam int DM_LO2  [NUM_SP] = '{0, 0, -25, -90, -36};
    localparam int DM_HI2  [NUM_SP] = '{1000, 10, 25, 90, 36};
    localparam int DM_BITS [NUM_SP] = '{12, 12, 16, 12, 12};

    localparam logic [7:0] CMD_FILL     = 8'hFF;
    localparam logic [7:0] TAIL_ENABLE  = 8'hFC;
    localparam logic [7:0] TAIL_ZERO    = 8'hFE;
    localparam logic [7:0] TAIL_CLEAR   = 8'hFB;
    localparam logic [7:0] QUERY_CMD    = 8'hE0;
    localparam logic [7:0] MODE_POS     = 8'h01;
    localparam logic [7:0] MODE_VEL     = 8'h02;
    localparam logic [7:0] MODE_CUR     = 8'h03;
    localparam logic [7:0] BYTE_ZERO    = 8'h00;

    localparam logic [LEN_W-1:0] LEN_CMD   = 4'd8;
    localparam logic [LEN_W-1:0] LEN_QUERY = 4'd2;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic dm0;
        logic dm1;
        logic dm2;
        logic dm3;
    } lane_ctl_t;

endpackage

[sv/mcfe_lane.sv]
// ---------------------------------------------------------------------------
// mcfe_lane
// clamp, scale and constant divide of one setpoint into its unsigned code
// ---------------------------------------------------------------------------
module mcfe_lane
    import mcfe_pkg::*;
#(
    parameter int FRAC_BITS = 10,
    parameter int FIELD     = 0
)
(
    input  logic                     clk,
    input  logic signed [SP_W-1:0]   setpoint,
    input  lane_ctl_t                ctl,
    output logic [CODE_W-1:0]        code
);

    localparam int UNIT    = 1 << (FRAC_BITS - 1);
    localparam int EC_SPAN = EC_HI2[FIELD] - EC_LO2[FIELD];
    localparam int DM_SPAN = DM_HI2[FIELD] - DM_LO2[FIELD];

    localparam logic signed [LIM_W-1:0] EC_LO = LIM_W'(EC_LO2[FIELD] * UNIT);
    localparam logic signed [LIM_W-1:0] EC_HI = LIM_W'(EC_HI2[FIELD] * UNIT);
    localparam logic signed [LIM_W-1:0] DM_LO = LIM_W'(DM_LO2[FIELD] * UNIT);
    localparam logic signed [LIM_W-1:0] DM_HI = LIM_W'(DM_HI2[FIELD] * UNIT);

    localparam logic [CODE_W-1:0] EC_MAX = CODE_W'((1 << EC_BITS[FIELD]) - 1);
    localparam logic [CODE_W-1:0] DM_MAX = CODE_W'((1 << DM_BITS[FIELD]) - 1);

    localparam logic [RECIP_W-1:0] EC_RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / EC_SPAN);
    localparam logic [RECIP_W-1:0] DM_RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / DM_SPAN);

    localparam logic [SPAN_W-1:0] EC_SPAN_V = SPAN_W'(EC_SPAN);
    localparam logic [SPAN_W-1:0] DM_SPAN_V = SPAN_W'(DM_SPAN);

    logic signed [LIM_W-1:0]      x_ext;
    logic signed [LIM_W-1:0]      lo_sel;
    logic signed [LIM_W-1:0]      hi_sel;
    logic signed [LIM_W-1:0]      x_clamp;
    logic [D_W-1:0]               d_next;
    logic [D_W-1:0]               d_reg;

    logic [CODE_W-1:0]            max_sel;
    logic [D_W+CODE_W-1:0]        prod_scale;
    logic [Q_W-1:0]               q_next;
    logic [Q_W-1:0]               q_reg;

    logic [RECIP_W-1:0]           recip_sel;
    logic [Q_W+RECIP_W-1:0]       prod_recip;
    logic [CODE_W-1:0]            est_next;
    logic [CODE_W-1:0]            est_reg;
    logic [Q_W-1:0]               q3_reg;

    logic [SPAN_W-1:0]            span_sel;
    logic [Q_W-1:0]               prod_fix;
    logic [Q_W-1:0]               rem;

    // stage 1: clamp and offset
    assign x_ext   = LIM_W'(setpoint);
    assign lo_sel  = ctl.dm0 ? DM_LO : EC_LO;
    assign hi_sel  = ctl.dm0 ? DM_HI : EC_HI;
    assign x_clamp = (x_ext < lo_sel) ? lo_sel : ((x_ext > hi_sel) ? hi_sel : x_ext);
    assign d_next  = D_W'(x_clamp - lo_sel);

    // stage 2: scale by full code and drop the fraction unit
    assign max_sel    = ctl.dm1 ? DM_MAX : EC_MAX;
    assign prod_scale = (D_W+CODE_W)'(d_reg) * (D_W+CODE_W)'(max_sel);
    assign q_next     = Q_W'(prod_scale >> (FRAC_BITS - 1));

    // stage 3: reciprocal estimate, low by at most one
    assign recip_sel  = ctl.dm2 ? DM_RECIP : EC_RECIP;
    assign prod_recip = (Q_W+RECIP_W)'(q_reg) * (Q_W+RECIP_W)'(recip_sel);
    assign est_next   = CODE_W'(prod_recip >> RECIP_SHIFT);

    // correction of the estimate
    assign span_sel = ctl.dm3 ? DM_SPAN_V : EC_SPAN_V;
    assign prod_fix = Q_W'(Q_W'(est_reg) * Q_W'(span_sel));
    assign rem      = q3_reg - prod_fix;
    assign code     = (rem >= Q_W'(span_sel)) ? CODE_W'(est_reg + CODE_W'(1)) : est_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.en1)
        begin
            d_reg <= d_next;
        end
        if (ctl.en2)
        begin
            q_reg <= q_next;
        end
        if (ctl.en3)
        begin
            est_reg <= est_next;
            q3_reg  <= q_reg;
        end
    end

endmodule

[sv/mcfe_pack.sv]
// ---------------------------------------------------------------------------
// mcfe_pack
// frame assembly and output register
// ---------------------------------------------------------------------------
module mcfe_pack
    import mcfe_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  func_t               func,
    input  logic [ID_W-1:0]     node_id,
    input  logic [CODE_W-1:0]   kp,
    input  logic [CODE_W-1:0]   kd,
    input  logic [CODE_W-1:0]   ps,
    input  logic [CODE_W-1:0]   vl,
    input  logic [CODE_W-1:0]   tq,
    output logic [ID_W-1:0]     frame_id,
    output logic [LEN_W-1:0]    frame_len,
    output logic [7:0]          bytes [8]
);

    logic [ID_W-1:0]  id_reg;
    logic [LEN_W-1:0] len_next;
    logic [LEN_W-1:0] len_reg;
    logic [7:0]       b_next [8];
    logic [7:0]       b_reg  [8];

    always_comb
    begin
        len_next = LEN_CMD;
        for (int i = 0; i < 8; i++)
        begin
            b_next[i] = BYTE_ZERO;
        end
        case (func)
            FUNC_EC_MIT:
            begin
                b_next[0] = {3'b000, kp[11:7]};
                b_next[1] = {kp[6:0], kd[8]};
                b_next[2] = kd[7:0];
                b_next[3] = ps[15:8];
                b_next[4] = ps[7:0];
                b_next[5] = vl[11:4];
                b_next[6] = {vl[3:0], tq[11:8]};
                b_next[7] = tq[7:0];
            end
            FUNC_DM_MIT:
            begin
                b_next[0] = ps[15:8];
                b_next[1] = ps[7:0];
                b_next[2] = vl[11:4];
                b_next[3] = {vl[3:0], kp[11:8]};
                b_next[4] = kp[7:0];
                b_next[5] = kd[11:4];
                b_next[6] = {kd[3:0], tq[11:8]};
                b_next[7] = tq[7:0];
            end
            FUNC_ENABLE, FUNC_ZERO, FUNC_CLEAR:
            begin
                for (int i = 0; i < 7; i++)
                begin
                    b_next[i] = CMD_FILL;
                end
                if (func == FUNC_ENABLE)
                begin
                    b_next[7] = TAIL_ENABLE;
                end
                else if (func == FUNC_ZERO)
                begin
                    b_next[7] = TAIL_ZERO;
                end
                else
                begin
                    b_next[7] = TAIL_CLEAR;
                end
            end
            FUNC_QUERY_POS:
            begin
                len_next  = LEN_QUERY;
                b_next[0] = QUERY_CMD;
                b_next[1] = MODE_POS;
            end
            FUNC_QUERY_VEL:
            begin
                len_next  = LEN_QUERY;
                b_next[0] = QUERY_CMD;
                b_next[1] = MODE_VEL;
            end
            FUNC_QUERY_CUR:
            begin
                len_next  = LEN_QUERY;
                b_next[0] = QUERY_CMD;
                b_next[1] = MODE_CUR;
            end
            default:
            begin
                len_next = LEN_CMD;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            id_reg  <= node_id;
            len_reg <= len_next;
            b_reg   <= b_next;
        end
    end

    assign frame_id  = id_reg;
    assign frame_len = len_reg;
    assign bytes     = b_reg;

endmodule

[sv/motor_command_frame_encoder_top.sv]
// ---------------------------------------------------------------------------
// motor_command_frame_encoder_top
// builds one can command frame, 8 bytes or a 2-byte query, per command transfer
// ---------------------------------------------------------------------------
// usage:
//   command channel: cmd_valid / cmd_stall with func, node_id and the five
//   setpoints (signed, FRAC_BITS fraction bits). a transfer completes on a
//   clock edge with cmd_valid high and cmd_stall low.
//   frame channel: frame_valid / frame_stall with frame_id, frame_len and
//   byte0..byte7, one frame per command, in command order.
//   pipeline: the command passes the clamp, scale, reciprocal and
//   pack/correct register stages in that order; frame_valid is the valid
//   bit of the pack/correct stage.
//   throughput: one command per cycle while cmd_stall is low; each stage
//   holds one item; an empty stage keeps filling while a later one waits.
//   reset: all valid bits clear, frame_valid low, cmd_stall low.
//   receiver stall: the frame holds in the output register, the stages
//   fill up behind it, and cmd_stall rises once every stage is occupied.
// ---------------------------------------------------------------------------
`include "motor_command_frame_encoder_top_defines.svh"

module motor_command_frame_encoder_top
    import mcfe_pkg::*;
#(
    parameter int FRAC_BITS = 10
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    output logic                    cmd_stall,
    input  logic [2:0]              func,
    input  logic [ID_W-1:0]         node_id,
    input  logic signed [SP_W-1:0]  stiffness,
    input  logic signed [SP_W-1:0]  damping,
    input  logic signed [SP_W-1:0]  position,
    input  logic signed [SP_W-1:0]  speed,
    input  logic signed [SP_W-1:0]  torque,
    output logic                    frame_valid,
    input  logic                    frame_stall,
    output logic [ID_W-1:0]         frame_id,
    output logic [LEN_W-1:0]        frame_len,
    output logic [7:0]              byte0,
    output logic [7:0]              byte1,
    output logic [7:0]              byte2,
    output logic [7:0]              byte3,
    output logic [7:0]              byte4,
    output logic [7:0]              byte5,
    output logic [7:0]              byte6,
    output logic [7:0]              byte7
);

    logic en1;
    logic en2;
    logic en3;
    logic en4;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v4_reg;
    logic v1_next;
    logic v2_next;
    logic v3_next;
    logic v4_next;

    func_t           func1_reg;
    func_t           func2_reg;
    func_t           func3_reg;
    func_t           func1_next;
    logic [ID_W-1:0] id1_reg;
    logic [ID_W-1:0] id2_reg;
    logic [ID_W-1:0] id3_reg;

    lane_ctl_t               lane_ctl;
    logic signed [SP_W-1:0]  sp    [NUM_SP];
    logic [CODE_W-1:0]       codes [NUM_SP];
    logic [7:0]              frame_bytes [8];

    logic pipe_full;
    logic frame_shape_ok;

    // stage enables, a stage moves when its slot is empty or the next one moves
    assign en4       = !v4_reg || !frame_stall;
    assign en3       = !v3_reg || en4;
    assign en2       = !v2_reg || en3;
    assign en1       = !v1_reg || en2;
    assign cmd_stall = !en1;

    assign v1_next = en1 ? cmd_valid : v1_reg;
    assign v2_next = en2 ? v1_reg : v2_reg;
    assign v3_next = en3 ? v2_reg : v3_reg;
    assign v4_next = en4 ? v3_reg : v4_reg;

    assign func1_next = func_t'(func);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            func1_reg <= func1_next;
            id1_reg   <= node_id;
        end
        if (en2)
        begin
            func2_reg <= func1_reg;
            id2_reg   <= id1_reg;
        end
        if (en3)
        begin
            func3_reg <= func2_reg;
            id3_reg   <= id2_reg;
        end
    end

    assign lane_ctl.en1 = en1;
    assign lane_ctl.en2 = en2;
    assign lane_ctl.en3 = en3;
    assign lane_ctl.dm0 = (func1_next == FUNC_DM_MIT);
    assign lane_ctl.dm1 = (func1_reg == FUNC_DM_MIT);
    assign lane_ctl.dm2 = (func2_reg == FUNC_DM_MIT);
    assign lane_ctl.dm3 = (func3_reg == FUNC_DM_MIT);

    assign sp[FIELD_KP] = stiffness;
    assign sp[FIELD_KD] = damping;
    assign sp[FIELD_PS] = position;
    assign sp[FIELD_VL] = speed;
    assign sp[FIELD_TQ] = torque;

    for (genvar g = 0; g < NUM_SP; g++)
    begin : g_lane
        mcfe_lane #(
            .FRAC_BITS (FRAC_BITS),
            .FIELD     (g)
        ) u_lane (
            .clk      (clk),
            .setpoint (sp[g]),
            .ctl      (lane_ctl),
            .code     (codes[g])
        );
    end

    mcfe_pack u_pack (
        .clk       (clk),
        .en        (en4),
        .func      (func3_reg),
        .node_id   (id3_reg),
        .kp        (codes[FIELD_KP]),
        .kd        (codes[FIELD_KD]),
        .ps        (codes[FIELD_PS]),
        .vl        (codes[FIELD_VL]),
        .tq        (codes[FIELD_TQ]),
        .frame_id  (frame_id),
        .frame_len (frame_len),
        .bytes     (frame_bytes)
    );

    assign frame_valid = v4_reg;
    assign byte0       = frame_bytes[0];
    assign byte1       = frame_bytes[1];
    assign byte2       = frame_bytes[2];
    assign byte3       = frame_bytes[3];
    assign byte4       = frame_bytes[4];
    assign byte5       = frame_bytes[5];
    assign byte6       = frame_bytes[6];
    assign byte7       = frame_bytes[7];

    assign pipe_full      = v1_reg && v2_reg && v3_reg && frame_valid && frame_stall;
    assign frame_shape_ok = (frame_len == LEN_CMD)
                            || ((frame_len == LEN_QUERY) && (byte0 == QUERY_CMD)
                                && (byte2 == BYTE_ZERO) && (byte3 == BYTE_ZERO)
                                && (byte4 == BYTE_ZERO) && (byte5 == BYTE_ZERO)
                                && (byte6 == BYTE_ZERO) && (byte7 == BYTE_ZERO));

    // back-pressure only when every stage holds an item
    `MCFE_ASSERT_IMPL(a_stall_full, clk, rst_n, cmd_stall, pipe_full)

    // an item waiting in the first stage is never dropped
    `MCFE_ASSERT_NEXT(a_stage1_hold, clk, rst_n, v1_reg && !en2, v1_reg)

    // frames are full commands or two-byte queries with zero tail
    `MCFE_ASSERT_IMPL(a_frame_shape, clk, rst_n, frame_valid, frame_shape_ok)

endmodule

[test/mcfe_frame_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcfe_frame_checker
// watches the command and frame channels of the motor command frame encoder,
// builds the expected can frame for every command transfer and compares each
// frame transfer against the oldest pending one, field by field
// ---------------------------------------------------------------------------
module mcfe_frame_checker
    import mcfe_pkg::*;
#(
    parameter int FRAC_BITS = 10
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    input  logic                    cmd_stall,
    input  logic [2:0]              func,
    input  logic [ID_W-1:0]         node_id,
    input  logic signed [SP_W-1:0]  stiffness,
    input  logic signed [SP_W-1:0]  damping,
    input  logic signed [SP_W-1:0]  position,
    input  logic signed [SP_W-1:0]  speed,
    input  logic signed [SP_W-1:0]  torque,
    input  logic                    frame_valid,
    input  logic                    frame_stall,
    input  logic [ID_W-1:0]         frame_id,
    input  logic [LEN_W-1:0]        frame_len,
    input  logic [7:0]              byte0,
    input  logic [7:0]              byte1,
    input  logic [7:0]              byte2,
    input  logic [7:0]              byte3,
    input  logic [7:0]              byte4,
    input  logic [7:0]              byte5,
    input  logic [7:0]              byte6,
    input  logic [7:0]              byte7,
    output int                      mismatches,
    output int                      outstanding
);

    localparam longint HALF_LSB = longint'(1) << (FRAC_BITS - 1);
    localparam int     REPORT_MAX = 10;

    localparam logic [7:0]       FRAME_FILL      = 8'hFF;
    localparam logic [7:0]       FRAME_TAIL_EN   = 8'hFC;
    localparam logic [7:0]       FRAME_TAIL_ZERO = 8'hFE;
    localparam logic [7:0]       FRAME_TAIL_CLR  = 8'hFB;
    localparam logic [7:0]       FRAME_QUERY     = 8'hE0;
    localparam logic [7:0]       QMODE_POS       = 8'h01;
    localparam logic [7:0]       QMODE_VEL       = 8'h02;
    localparam logic [7:0]       QMODE_CUR       = 8'h03;
    localparam logic [LEN_W-1:0] FRAME_LEN_CMD   = 4'd8;
    localparam logic [LEN_W-1:0] FRAME_LEN_QUERY = 4'd2;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [LEN_W-1:0] len;
        logic [7:0][7:0]  data;
    } frame_rec_t;

    frame_rec_t expected_frames[$];
    frame_rec_t got_frame;
    frame_rec_t want_frame;
    int         err_total = 0;

    // clamp to [lo, hi] in half units, then floor((x - lo) * (2^bits - 1) / (hi - lo))
    function automatic logic [15:0] quantize(logic signed [SP_W-1:0] raw, int lo2, int hi2,
                                             int bits);
        longint lo;
        longint hi;
        longint x;
        lo = longint'(lo2) * HALF_LSB;
        hi = longint'(hi2) * HALF_LSB;
        x  = raw;
        if (x < lo)
        begin
            x = lo;
        end
        if (x > hi)
        begin
            x = hi;
        end
        return 16'(((x - lo) * ((longint'(1) << bits) - 1)) / (hi - lo));
    endfunction

    function automatic frame_rec_t encode_frame(logic [2:0] f, logic [ID_W-1:0] id,
                                                logic signed [SP_W-1:0] kp,
                                                logic signed [SP_W-1:0] kd,
                                                logic signed [SP_W-1:0] ps,
                                                logic signed [SP_W-1:0] vl,
                                                logic signed [SP_W-1:0] tq);
        frame_rec_t fr;
        logic [15:0] q_kp;
        logic [15:0] q_kd;
        logic [15:0] q_ps;
        logic [15:0] q_vl;
        logic [15:0] q_tq;
        fr.id   = id;
        fr.len  = FRAME_LEN_CMD;
        fr.data = '0;
        case (func_t'(f))
            FUNC_EC_MIT:
            begin
                q_kp = quantize(kp, 0, 1000, 12);
                q_kd = quantize(kd, 0, 10, 9);
                q_ps = quantize(ps, -25, 25, 16);
                q_vl = quantize(vl, -36, 36, 12);
                q_tq = quantize(tq, -60, 60, 12);
                fr.data[0] = {3'b000, q_kp[11:7]};
                fr.data[1] = {q_kp[6:0], q_kd[8]};
                fr.data[2] = q_kd[7:0];
                fr.data[3] = q_ps[15:8];
                fr.data[4] = q_ps[7:0];
                fr.data[5] = q_vl[11:4];
                fr.data[6] = {q_vl[3:0], q_tq[11:8]};
                fr.data[7] = q_tq[7:0];
            end
            FUNC_DM_MIT:
            begin
                q_kp = quantize(kp, 0, 1000, 12);
                q_kd = quantize(kd, 0, 10, 12);
                q_ps = quantize(ps, -25, 25, 16);
                q_vl = quantize(vl, -90, 90, 12);
                q_tq = quantize(tq, -36, 36, 12);
                fr.data[0] = q_ps[15:8];
                fr.data[1] = q_ps[7:0];
                fr.data[2] = q_vl[11:4];
                fr.data[3] = {q_vl[3:0], q_kp[11:8]};
                fr.data[4] = q_kp[7:0];
                fr.data[5] = q_kd[11:4];
                fr.data[6] = {q_kd[3:0], q_tq[11:8]};
                fr.data[7] = q_tq[7:0];
            end
            FUNC_ENABLE, FUNC_ZERO, FUNC_CLEAR:
            begin
                for (int b = 0; b < 7; b++)
                begin
                    fr.data[b] = FRAME_FILL;
                end
                if (func_t'(f) == FUNC_ENABLE)
                begin
                    fr.data[7] = FRAME_TAIL_EN;
                end
                else if (func_t'(f) == FUNC_ZERO)
                begin
                    fr.data[7] = FRAME_TAIL_ZERO;
                end
                else
                begin
                    fr.data[7] = FRAME_TAIL_CLR;
                end
            end
            default:
            begin
                fr.len     = FRAME_LEN_QUERY;
                fr.data[0] = FRAME_QUERY;
                if (func_t'(f) == FUNC_QUERY_POS)
                begin
                    fr.data[1] = QMODE_POS;
                end
                else if (func_t'(f) == FUNC_QUERY_VEL)
                begin
                    fr.data[1] = QMODE_VEL;
                end
                else
                begin
                    fr.data[1] = QMODE_CUR;
                end
            end
        endcase
        return fr;
    endfunction

    task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            err_total++;
            if (err_total <= REPORT_MAX)
            begin
                $display("%0t frame mismatch on %0s: expected %0h, got %0h",
                         $realtime, field, want, got);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                expected_frames.push_back(encode_frame(func, node_id, stiffness, damping,
                                                       position, speed, torque));
            end
            if (frame_valid && !frame_stall)
            begin
                got_frame = '{frame_id, frame_len,
                              {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0}};
                if (expected_frames.size() == 0)
                begin
                    err_total++;
                    if (err_total <= REPORT_MAX)
                    begin
                        $display("%0t unexpected frame transfer, id %0h", $realtime, frame_id);
                    end
                end
                else
                begin
                    want_frame = expected_frames.pop_front();
                    check_field("frame_id", 16'(want_frame.id), 16'(got_frame.id));
                    check_field("frame_len", 16'(want_frame.len), 16'(got_frame.len));
                    for (int b = 0; b < 8; b++)
                    begin
                        check_field($sformatf("byte%0d", b), 16'(want_frame.data[b]),
                                    16'(got_frame.data[b]));
                    end
                end
            end
            mismatches  <= err_total;
            outstanding <= expected_frames.size();
        end
    end

endmodule

[test/tb_motor_command_frame_encoder_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_motor_command_frame_encoder_top
// drives commands into the motor command frame encoder with random gaps and
// random frame stalls: a directed sweep over the setpoint limits and every
// frame type, then random commands mostly near or inside the limits; the
// checker predicts every frame and reports the failure count for the verdict
// ---------------------------------------------------------------------------
module tb_motor_command_frame_encoder_top;
    import mcfe_pkg::*;

    localparam int FRAC_BITS    = 10;
    localparam int HALF_LSB     = 1 << (FRAC_BITS - 1);
    localparam int SP_MAX       = (1 << (SP_W - 1)) - 1;
    localparam int SP_MIN       = -(1 << (SP_W - 1));
    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;

    localparam int SWEEP_LOW   = 0;
    localparam int SWEEP_HIGH  = 1;
    localparam int SWEEP_CONST = 2;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cmd_valid = 1'b0;
    logic                   cmd_stall;
    logic [2:0]             cmd_func = '0;
    logic [ID_W-1:0]        cmd_id = '0;
    logic signed [SP_W-1:0] cmd_kp = '0;
    logic signed [SP_W-1:0] cmd_kd = '0;
    logic signed [SP_W-1:0] cmd_ps = '0;
    logic signed [SP_W-1:0] cmd_vl = '0;
    logic signed [SP_W-1:0] cmd_tq = '0;
    logic                   frame_valid;
    logic                   frame_stall = 1'b0;
    logic [ID_W-1:0]        frame_id;
    logic [LEN_W-1:0]       frame_len;
    logic [7:0]             byte0;
    logic [7:0]             byte1;
    logic [7:0]             byte2;
    logic [7:0]             byte3;
    logic [7:0]             byte4;
    logic [7:0]             byte5;
    logic [7:0]             byte6;
    logic [7:0]             byte7;
    int                     mismatches;
    int                     outstanding;
    int                     cycle_count = 0;
    int                     stall_left = 0;
    bit                     no_idle = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    motor_command_frame_encoder_top #(
        .FRAC_BITS   (FRAC_BITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .func        (cmd_func),
        .node_id     (cmd_id),
        .stiffness   (cmd_kp),
        .damping     (cmd_kd),
        .position    (cmd_ps),
        .speed       (cmd_vl),
        .torque      (cmd_tq),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame_id    (frame_id),
        .frame_len   (frame_len),
        .byte0       (byte0),
        .byte1       (byte1),
        .byte2       (byte2),
        .byte3       (byte3),
        .byte4       (byte4),
        .byte5       (byte5),
        .byte6       (byte6),
        .byte7       (byte7)
    );

    mcfe_frame_checker #(
        .FRAC_BITS   (FRAC_BITS)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .func        (cmd_func),
        .node_id     (cmd_id),
        .stiffness   (cmd_kp),
        .damping     (cmd_kd),
        .position    (cmd_ps),
        .speed       (cmd_vl),
        .torque      (cmd_tq),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame_id    (frame_id),
        .frame_len   (frame_len),
        .byte0       (byte0),
        .byte1       (byte1),
        .byte2       (byte2),
        .byte3       (byte3),
        .byte4       (byte4),
        .byte5       (byte5),
        .byte6       (byte6),
        .byte7       (byte7),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_idle || r < 55)
        begin
            return 0;
        end
        if (r < 93)
        begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 4);
    endfunction

    // upper limit of a setpoint in half units
    function automatic int hi_half(bit dm, int k);
        case (k)
            FIELD_KP: return 1000;
            FIELD_KD: return 10;
            FIELD_PS: return 25;
            FIELD_VL: return dm ? 90 : 36;
            default:  return dm ? 36 : 60;
        endcase
    endfunction

    function automatic logic [SP_W-1:0] pick_setpoint(bit dm, int k);
        int hi;
        int lo;
        int r;
        hi = hi_half(dm, k) * HALF_LSB;
        lo = (k == FIELD_KP || k == FIELD_KD) ? 0 : -hi;
        r  = $urandom_range(99);
        if (r < 55)
        begin
            return SP_W'(lo + int'($urandom_range(hi - lo)));
        end
        if (r < 75)
        begin
            return SP_W'((r[0] ? hi : lo) + int'($urandom_range(6)) - 3);
        end
        return SP_W'($urandom);
    endfunction

    always @(posedge clk)
    begin
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[motor_command_frame_encoder_top] ERROR");
            $finish;
        end
        cycle_count <= cycle_count + 1;
    end

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            frame_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end
        else
        begin
            frame_stall <= 1'b0;
            if ($urandom_range(3) == 0)
            begin
                stall_left <= pick_gap();
            end
        end
    end

    task automatic send_command(func_t f, logic [ID_W-1:0] id, logic [SP_W-1:0] kp,
                                logic [SP_W-1:0] kd, logic [SP_W-1:0] ps,
                                logic [SP_W-1:0] vl, logic [SP_W-1:0] tq);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_func  <= f;
        cmd_id    <= id;
        cmd_kp    <= kp;
        cmd_kd    <= kd;
        cmd_ps    <= ps;
        cmd_vl    <= vl;
        cmd_tq    <= tq;
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
    endtask

    // all five setpoints at the low or the high limit plus an offset, or all at the offset as one constant
    task automatic sweep_command(func_t f, logic [ID_W-1:0] id, int mode, int offset);
        logic [SP_W-1:0] sp [NUM_SP];
        int hi;
        int lo;
        for (int k = 0; k < NUM_SP; k++)
        begin
            hi = hi_half(f == FUNC_DM_MIT, k) * HALF_LSB;
            lo = (k == FIELD_KP || k == FIELD_KD) ? 0 : -hi;
            if (mode == SWEEP_CONST)
            begin
                sp[k] = SP_W'(offset);
            end
            else
            begin
                sp[k] = SP_W'(((mode == SWEEP_HIGH) ? hi : lo) + offset);
            end
        end
        send_command(f, id, sp[FIELD_KP], sp[FIELD_KD], sp[FIELD_PS], sp[FIELD_VL],
                     sp[FIELD_TQ]);
    endtask

    task automatic random_command();
        logic [SP_W-1:0] sp [NUM_SP];
        func_t f;
        int r;
        r = $urandom_range(99);
        if (r < 40)
        begin
            f = FUNC_EC_MIT;
        end
        else if (r < 80)
        begin
            f = FUNC_DM_MIT;
        end
        else
        begin
            f = func_t'($urandom_range(7));
        end
        for (int k = 0; k < NUM_SP; k++)
        begin
            sp[k] = pick_setpoint(f == FUNC_DM_MIT, k);
        end
        send_command(f, ID_W'($urandom), sp[FIELD_KP], sp[FIELD_KD], sp[FIELD_PS],
                     sp[FIELD_VL], sp[FIELD_TQ]);
    endtask

    // stop sending until every pending frame has come out
    task automatic wait_for_frames();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        func_t f;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // limits, one step past them and the extremes of the 24-bit range
        for (int m = 0; m < 2; m++)
        begin
            f = m ? FUNC_DM_MIT : FUNC_EC_MIT;
            sweep_command(f, '0, SWEEP_LOW, 0);
            sweep_command(f, '1, SWEEP_LOW, -1);
            sweep_command(f, ID_W'($urandom), SWEEP_HIGH, 0);
            sweep_command(f, ID_W'($urandom), SWEEP_HIGH, 1);
            sweep_command(f, ID_W'($urandom), SWEEP_CONST, SP_MAX);
            sweep_command(f, ID_W'($urandom), SWEEP_CONST, SP_MIN);
            sweep_command(f, ID_W'($urandom), SWEEP_CONST, 0);
        end
        for (int c = FUNC_ENABLE; c <= FUNC_QUERY_CUR; c++)
        begin
            send_command(func_t'(c), ID_W'($urandom), SP_W'($urandom), SP_W'($urandom),
                         SP_W'($urandom), SP_W'($urandom), SP_W'($urandom));
        end
        wait_for_frames();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 250 == 125)
            begin
                wait_for_frames();
            end
            no_idle <= ((n / 100) % 4 == 3);
            random_command();
        end

        wait_for_frames();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("[motor_command_frame_encoder_top] OK");
        end
        else
        begin
            $display("[motor_command_frame_encoder_top] ERROR");
        end
        $finish;
    end

endmodule

[motor_command_frame_encoder_top.f]
+incdir+sv
sv/mcfe_pkg.sv
sv/mcfe_lane.sv
sv/mcfe_pack.sv
sv/motor_command_frame_encoder_top.sv
test/mcfe_frame_checker.sv
test/tb_motor_command_frame_encoder_top.sv
